@@ hw/rtl/meu_pkg.sv @@
package meu_pkg;

    // Field widths of the ports
    localparam int BASE_W  = 63;
    localparam int EXP_W   = 32;
    localparam int POWER_W = 32;
    localparam int MODCFG_W = 32;

    // Defaults for the top-level parameters
    localparam int MOD_BITS_DEFAULT = 32;
    localparam int EXP_BITS_DEFAULT = 32;

    // Step counter covers the longest serial pass (base reduction)
    localparam int CNT_W = $clog2(BASE_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_PICK,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } meu_state_t;

endpackage

@@ hw/rtl/modular_exponentiation_unit.sv @@
// Modular exponentiation unit: returns power = base ** exponent mod modulus by right-to-left
// binary square-and-multiply. The modulus is written through cfg_we/cfg_wdata (reset value 1)
// and may only change while no transaction is in flight. All arithmetic goes through a single
// shift/add/subtract step unit that does one bit of an MW-bit modular product per cycle
// (MW = min(MOD_BITS, 32)). A transaction first reduces the 63-bit base bit-serially, then,
// for each exponent bit up to the highest set one, multiplies when the bit is set and then
// squares (skipped after the highest set bit). A zero exponent returns 1, and otherwise a
// modulus of 0 or 1 returns 0, both without the serial passes. s_ready is high only while
// the unit is idle; the result waits in an output register until taken.
module modular_exponentiation_unit #(
    parameter int MOD_BITS = meu_pkg::MOD_BITS_DEFAULT,
    parameter int EXP_BITS = meu_pkg::EXP_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [meu_pkg::MODCFG_W-1:0] cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [meu_pkg::BASE_W-1:0]   s_base,
    input  logic [meu_pkg::EXP_W-1:0]    s_exponent,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [meu_pkg::POWER_W-1:0]  m_power
);

    localparam int MW = (MOD_BITS < meu_pkg::MODCFG_W) ? MOD_BITS : meu_pkg::MODCFG_W;
    localparam int EW = (EXP_BITS < meu_pkg::EXP_W) ? EXP_BITS : meu_pkg::EXP_W;
    localparam int CW = meu_pkg::CNT_W;

    meu_pkg::meu_state_t state_reg, state_next;

    logic [MW-1:0]                 modulus_reg;
    logic [MW-1:0]                 acc_reg, acc_next;
    logic [MW-1:0]                 res_reg, res_next;
    logic [MW-1:0]                 base_reg, base_next;
    logic [MW-1:0]                 mplr_reg, mplr_next;
    logic [EW-1:0]                 exp_reg, exp_next;
    logic [meu_pkg::BASE_W-1:0]    num_reg, num_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [meu_pkg::POWER_W-1:0]   power_reg, power_next;
    logic                          m_valid_reg, m_valid_next;

    // Shared step unit: acc <- (2*acc + (add_en ? addend : 0)) mod m
    logic [MW-1:0] step_addend;
    logic          step_add_en;
    logic [MW:0]   step_dbl;
    logic [MW:0]   step_mod;
    logic [MW-1:0] step_half;
    logic [MW:0]   step_sum;
    logic [MW-1:0] step_out;

    assign step_mod = {1'b0, modulus_reg};
    assign step_dbl = {acc_reg, 1'b0};

    always_comb begin
        step_half = (step_dbl >= step_mod) ? MW'(step_dbl - step_mod) : step_dbl[MW-1:0];
        step_sum  = {1'b0, step_half} + {1'b0, (step_add_en ? step_addend : '0)};
        step_out  = (step_sum >= step_mod) ? MW'(step_sum - step_mod) : step_sum[MW-1:0];
    end

    // Select the step operand for the current pass
    always_comb begin
        case (state_reg)
            meu_pkg::ST_REDUCE: begin
                step_addend = MW'(num_reg[meu_pkg::BASE_W-1]);
                step_add_en = 1'b1;
            end
            meu_pkg::ST_MUL: begin
                step_addend = res_reg;
                step_add_en = mplr_reg[MW-1];
            end
            meu_pkg::ST_SQR: begin
                step_addend = base_reg;
                step_add_en = mplr_reg[MW-1];
            end
            default: begin
                step_addend = '0;
                step_add_en = 1'b0;
            end
        endcase
    end

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        base_next    = base_reg;
        mplr_next    = mplr_reg;
        exp_next     = exp_reg;
        num_next     = num_reg;
        cnt_next     = cnt_reg;
        power_next   = power_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            meu_pkg::ST_IDLE: begin
                if (s_valid) begin
                    num_next = s_base;
                    exp_next = s_exponent[EW-1:0];
                    acc_next = '0;
                    cnt_next = CW'(meu_pkg::BASE_W - 1);
                    if (s_exponent[EW-1:0] == '0) begin
                        res_next   = MW'(1);
                        state_next = meu_pkg::ST_DONE;
                    end else if (modulus_reg <= MW'(1)) begin
                        res_next   = '0;
                        state_next = meu_pkg::ST_DONE;
                    end else begin
                        res_next   = MW'(1);
                        state_next = meu_pkg::ST_REDUCE;
                    end
                end
            end
            meu_pkg::ST_REDUCE: begin
                // Reduce the base one bit per cycle, most significant first
                acc_next = step_out;
                num_next = num_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    base_next  = step_out;
                    state_next = meu_pkg::ST_PICK;
                end
            end
            meu_pkg::ST_PICK: begin
                // Stop once no set exponent bits remain
                if (exp_reg == '0) begin
                    state_next = meu_pkg::ST_DONE;
                end else begin
                    acc_next   = '0;
                    mplr_next  = base_reg;
                    cnt_next   = CW'(MW - 1);
                    state_next = exp_reg[0] ? meu_pkg::ST_MUL : meu_pkg::ST_SQR;
                end
            end
            meu_pkg::ST_MUL: begin
                acc_next  = step_out;
                mplr_next = mplr_reg << 1;
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    res_next    = step_out;
                    exp_next[0] = 1'b0;
                    state_next  = meu_pkg::ST_PICK;
                end
            end
            meu_pkg::ST_SQR: begin
                acc_next  = step_out;
                mplr_next = mplr_reg << 1;
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    base_next  = step_out;
                    exp_next   = exp_reg >> 1;
                    state_next = meu_pkg::ST_PICK;
                end
            end
            meu_pkg::ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    power_next   = meu_pkg::POWER_W'(res_reg);
                    m_valid_next = 1'b1;
                    state_next   = meu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = meu_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= meu_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            modulus_reg <= MW'(1);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                modulus_reg <= cfg_wdata[MW-1:0];
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        res_reg   <= res_next;
        base_reg  <= base_next;
        mplr_reg  <= mplr_next;
        exp_reg   <= exp_next;
        num_reg   <= num_next;
        cnt_reg   <= cnt_next;
        power_reg <= power_next;
    end

    assign s_ready = (state_reg == meu_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_power = power_reg;

    // The accumulator stays reduced during every serial pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == meu_pkg::ST_REDUCE || state_reg == meu_pkg::ST_MUL
         || state_reg == meu_pkg::ST_SQR) |-> (acc_reg < modulus_reg))
        else $error("accumulator not below modulus");

    // Running result and base power stay reduced inside the loop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == meu_pkg::ST_PICK || state_reg == meu_pkg::ST_MUL
         || state_reg == meu_pkg::ST_SQR)
        |-> (res_reg < modulus_reg && base_reg < modulus_reg))
        else $error("operand not below modulus");

    // An accepted transaction leaves idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != meu_pkg::ST_IDLE))
        else $error("accepted transaction did not start");

    // The last step of a product returns to the exponent scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == meu_pkg::ST_MUL || state_reg == meu_pkg::ST_SQR) && cnt_reg == '0)
        |=> (state_reg == meu_pkg::ST_PICK))
        else $error("product pass did not end");

    // A result is loaded only when the output register was free or being drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == meu_pkg::ST_DONE && m_valid_reg && !m_ready)
        |=> (state_reg == meu_pkg::ST_DONE))
        else $error("result overwrote pending output");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

// Expected-power ledger: predicts each power from the operands and the current modulus,
// holds the predictions in order and compares them with the results taken from the block
class power_ledger;
    logic [meu_pkg::MODCFG_W-1:0] modulus = 1;
    logic [meu_pkg::POWER_W-1:0]  pending_powers[$];
    int unsigned                  operands_noted;
    int unsigned                  results_seen;
    int unsigned                  mismatches;

    // Right-to-left square-and-multiply; products of two values below 2**32 fit in 64 bits
    function logic [meu_pkg::POWER_W-1:0] mod_power(logic [meu_pkg::BASE_W-1:0] b,
                                                    logic [meu_pkg::EXP_W-1:0] e);
        longint unsigned m;
        longint unsigned sq;
        longint unsigned acc;
        m = 64'(modulus);
        if (e == 0) begin
            return 1;
        end
        if (m <= 1) begin
            return 0;
        end
        sq  = {1'b0, b} % m;
        acc = 1;
        for (int i = 0; i < meu_pkg::EXP_W; i++) begin
            if (e[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc[meu_pkg::POWER_W-1:0];
    endfunction

    function void note_operands(logic [meu_pkg::BASE_W-1:0] b, logic [meu_pkg::EXP_W-1:0] e);
        pending_powers.push_back(mod_power(b, e));
        operands_noted++;
    endfunction

    function void check_power(logic [meu_pkg::POWER_W-1:0] actual);
        logic [meu_pkg::POWER_W-1:0] predicted;
        results_seen++;
        if (pending_powers.size() == 0) begin
            $error("power: no result pending, actual %0d", actual);
            mismatches++;
            return;
        end
        predicted = pending_powers.pop_front();
        if (actual !== predicted) begin
            $error("power: expected %0d, actual %0d", predicted, actual);
            mismatches++;
        end
    endfunction
endclass

module testbench;

    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int PHASE_ITEMS      = 28;
    localparam int NUM_PHASES       = 10;

    logic                         aclk       = 1'b0;
    logic                         aresetn    = 1'b0;
    logic                         cfg_we     = 1'b0;
    logic [meu_pkg::MODCFG_W-1:0] cfg_wdata  = '0;
    logic                         s_valid    = 1'b0;
    logic                         s_ready;
    logic [meu_pkg::BASE_W-1:0]   s_base     = '0;
    logic [meu_pkg::EXP_W-1:0]    s_exponent = '0;
    logic                         m_valid;
    logic                         m_ready    = 1'b0;
    logic [meu_pkg::POWER_W-1:0]  m_power;

    power_ledger ledger = new();

    int          burst_left;
    int          moduli_used;
    int          idle_cycles;
    int          hold_left;
    int          holds_done;
    int          stall_mode;
    int          stall_left;

    modular_exponentiation_unit i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_base     (s_base),
        .s_exponent (s_exponent),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_power    (m_power)
    );

    always #5 aclk = ~aclk;

    // Note accepted operands and check results on the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            ledger.note_operands(s_base, s_exponent);
        end
        if (aresetn && m_valid && m_ready) begin
            ledger.check_power(m_power);
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: long hold-offs at two points, otherwise stretches of random stall patterns
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left = hold_left - 1;
        end else if ((holds_done == 0 && ledger.results_seen >= 40) ||
                     (holds_done == 1 && ledger.results_seen >= 170)) begin
            holds_done = holds_done + 1;
            hold_left  = LONG_HOLD_CYCLES - 1;
            m_ready    = 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(20, 200);
            end
            stall_left = stall_left - 1;
            case (stall_mode)
                0:       m_ready = 1'b1;
                1:       m_ready = $urandom_range(0, 1);
                default: m_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Offer one operand pair, in bursts with random gaps; return once it is accepted
    task automatic offer_operands(input logic [meu_pkg::BASE_W-1:0] b,
                                  input logic [meu_pkg::EXP_W-1:0] e);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_valid    = 1'b0;
                s_base     = meu_pkg::BASE_W'({$urandom, $urandom});
                s_exponent = $urandom;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_valid    = 1'b1;
        s_base     = b;
        s_exponent = e;
        burst_left = burst_left - 1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every predicted power has been taken
    task automatic drain_results();
        @(negedge aclk);
        s_valid    = 1'b0;
        burst_left = 0;
        while (ledger.pending_powers.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_modulus(input logic [meu_pkg::MODCFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we         = 1'b0;
        cfg_wdata      = $urandom;
        ledger.modulus = value;
        moduli_used    = moduli_used + 1;
    endtask

    // Bases: zero, all ones, small, at and around the modulus, multiples of it, full random
    function automatic logic [meu_pkg::BASE_W-1:0] pick_base();
        logic [meu_pkg::BASE_W-1:0] m;
        m = {{(meu_pkg::BASE_W-meu_pkg::MODCFG_W){1'b0}}, ledger.modulus};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return meu_pkg::BASE_W'($urandom_range(0, 1000));
            4:       return m;
            5:       return m - 1;
            6:       return m * $urandom_range(2, 1000) + $urandom_range(0, 3);
            default: return meu_pkg::BASE_W'({$urandom, $urandom});
        endcase
    endfunction

    // Exponents: mostly short so the run stays fast, some at full width
    function automatic logic [meu_pkg::EXP_W-1:0] pick_exponent();
        case ($urandom_range(0, 19))
            0, 1:    return '0;
            2:       return 1;
            3:       return $urandom;
            4:       return '1;
            5, 6:    return $urandom_range(0, 65535);
            default: return $urandom_range(2, 255);
        endcase
    endfunction

    initial begin
        logic [meu_pkg::MODCFG_W-1:0] phase_moduli[NUM_PHASES];

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset modulus of one, then the extremes and each special case
        offer_operands(5, 0);
        offer_operands(5, 3);
        offer_operands('1, '1);
        drain_results();

        write_modulus('1);
        offer_operands(0, 0);
        offer_operands(0, 5);
        offer_operands('1, '1);
        offer_operands(63'hFFFF_FFFF, 3);
        offer_operands(63'hFFFF_FFFE, 2);
        offer_operands(63'h1_0000_0000, 1);
        offer_operands(2, 31);
        offer_operands(2, 32);
        offer_operands(123456789, 1);
        drain_results();

        write_modulus(0);
        offer_operands(3, 0);
        offer_operands(3, 9);
        drain_results();

        write_modulus(2);
        offer_operands(7, 1);
        offer_operands(8, 5);
        drain_results();

        write_modulus(32'h8000_0000);
        offer_operands(3, '1);
        offer_operands('1, 1);
        drain_results();

        // Random phases, one modulus setting each
        phase_moduli[0] = '1;
        phase_moduli[1] = 2;
        phase_moduli[2] = 3;
        phase_moduli[3] = 32'h8000_0000;
        phase_moduli[4] = {1'b1, 31'($urandom)};
        phase_moduli[5] = $urandom_range(4, 255);
        phase_moduli[6] = 1;
        phase_moduli[7] = 0;
        phase_moduli[8] = 32'hFFFF_FFFB;
        phase_moduli[9] = $urandom;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_modulus(phase_moduli[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                offer_operands(pick_base(), pick_exponent());
            end
            drain_results();
        end

        repeat (20) @(posedge aclk);
        $display("Ran %0d operand pairs under %0d modulus settings, %0d results checked.",
                 ledger.operands_noted, moduli_used, ledger.results_seen);
        $display("Included zero exponents, moduli of 0 and 1, full-width operands and bases "
                 , "at or above the modulus.");
        if (ledger.mismatches == 0 && ledger.pending_powers.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ modular_exponentiation_unit.f @@
hw/rtl/meu_pkg.sv
hw/rtl/modular_exponentiation_unit.sv
test/testbench.sv
